// ----- rtl/assert_macros.svh -----
// Assertion helpers for the RTL, included by rrwl_engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define RRWL_ASSERT_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define RRWL_ASSERT_CLK(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");
`else
`define RRWL_ASSERT_RST(label, clk, rst_n, prop)
`define RRWL_ASSERT_CLK(label, clk, prop)
`endif

`endif

// ----- rtl/rrwl_pkg.sv -----
`default_nettype none

package rrwl_pkg;

  localparam int unsigned THREAD_ID_W = 8;
  localparam int unsigned COUNT_OUT_W = 8;

  typedef enum logic [1:0] {
    OP_READ_ACQ  = 2'd0,
    OP_WRITE_ACQ = 2'd1,
    OP_READ_REL  = 2'd2,
    OP_WRITE_REL = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_WRITER    = 3'd1,
    ST_READER    = 3'd2,
    ST_UNDERFLOW = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_SINGLE = 2'd1,
    KIND_MANY   = 2'd2
  } kind_e;

  typedef struct packed {
    logic [1:0]             operation;
    logic [THREAD_ID_W-1:0] thread_id;
  } req_t;

  typedef struct packed {
    logic [2:0]             status;
    logic [1:0]             owner_kind;
    logic [COUNT_OUT_W-1:0] readers_held;
    logic [COUNT_OUT_W-1:0] write_depth_now;
  } rsp_t;

endpackage

`default_nettype wire

// ----- rtl/recursive_reader_writer_lock_core.sv -----
// Recursive reader/writer lock for one shared object. Each request carries an
// operation (read acquire, write acquire, read release, write release) and a
// thread id, and returns one response with a status and the owner kind, reader
// count and write depth after the request. Acquires never wait: a refused
// acquire reports writer or reader contention or count overflow, and the
// caller retries. The lock takes one request per clock cycle while the
// output is not stalled; each request goes through the input register, then
// the decision logic into the response register. THREAD_ID_BITS sets how many
// low bits of thread_id identify a thread (at most 8 are used); COUNT_BITS
// sets the width of the read and write counters (overflow at 2^COUNT_BITS-1).
`default_nettype none

module recursive_reader_writer_lock_core #(
  parameter int unsigned THREAD_ID_BITS = 8,
  parameter int unsigned COUNT_BITS     = 8
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire rrwl_pkg::req_t in_req_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output rrwl_pkg::rsp_t      out_rsp_o
);

  localparam int unsigned TidW = (THREAD_ID_BITS < rrwl_pkg::THREAD_ID_W) ?
                                 THREAD_ID_BITS : rrwl_pkg::THREAD_ID_W;

  logic           in_valid_q, in_valid_d;
  rrwl_pkg::req_t in_req_q;
  logic           out_free;
  logic           advance;
  logic           accept;
  rrwl_pkg::rsp_t rsp;

  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_req_q <= in_req_i;
    end
  end

  rrwl_engine #(
    .TID_W (TidW),
    .CNT_W (COUNT_BITS)
  ) u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .req_i  (in_req_q),
    .rsp_o  (rsp)
  );

  rrwl_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .rsp_i       (rsp),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

`default_nettype wire

// ----- rtl/rrwl_engine.sv -----
`default_nettype none

`include "assert_macros.svh"

module rrwl_engine #(
  parameter int unsigned TID_W = 8,
  parameter int unsigned CNT_W = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire rrwl_pkg::req_t req_i,
  output rrwl_pkg::rsp_t     rsp_o
);

  rrwl_pkg::kind_e kind_q, kind_d;
  logic [TID_W-1:0] thread_q, thread_d;
  logic [CNT_W-1:0] rc_q, rc_d;
  logic [CNT_W-1:0] wd_q, wd_d;
  rrwl_pkg::status_e status;

  logic [TID_W-1:0] tid;
  logic             owns;
  logic             rc_full;
  logic             wd_full;
  logic [CNT_W+rrwl_pkg::COUNT_OUT_W-1:0] rc_ext;
  logic [CNT_W+rrwl_pkg::COUNT_OUT_W-1:0] wd_ext;

  assign tid     = req_i.thread_id[TID_W-1:0];
  assign owns    = (kind_q == rrwl_pkg::KIND_SINGLE) && (thread_q == tid);
  assign rc_full = &rc_q;
  assign wd_full = &wd_q;

  always_comb begin
    kind_d   = kind_q;
    thread_d = thread_q;
    rc_d     = rc_q;
    wd_d     = wd_q;
    status   = rrwl_pkg::ST_OK;
    case (rrwl_pkg::op_e'(req_i.operation))
      rrwl_pkg::OP_READ_ACQ: begin
        if (!owns && wd_q != '0) begin
          status = rrwl_pkg::ST_WRITER;
        end else if (rc_full) begin
          status = rrwl_pkg::ST_OVERFLOW;
        end else begin
          if (!owns) begin
            if (rc_q != '0) begin
              kind_d   = rrwl_pkg::KIND_MANY;
              thread_d = '0;
            end else begin
              kind_d   = rrwl_pkg::KIND_SINGLE;
              thread_d = tid;
            end
          end
          rc_d = rc_q + 1'b1;
        end
      end
      rrwl_pkg::OP_WRITE_ACQ: begin
        if (owns) begin
          if (wd_full) begin
            status = rrwl_pkg::ST_OVERFLOW;
          end else begin
            wd_d = wd_q + 1'b1;
          end
        end else if (rc_q != '0) begin
          status = rrwl_pkg::ST_READER;
        end else if (wd_q != '0) begin
          status = rrwl_pkg::ST_WRITER;
        end else begin
          kind_d   = rrwl_pkg::KIND_SINGLE;
          thread_d = tid;
          wd_d     = {{(CNT_W-1){1'b0}}, 1'b1};
        end
      end
      rrwl_pkg::OP_READ_REL: begin
        if (rc_q == '0) begin
          status = rrwl_pkg::ST_UNDERFLOW;
        end else begin
          rc_d = rc_q - 1'b1;
          if (rc_d == '0 && wd_q == '0) begin
            kind_d   = rrwl_pkg::KIND_NONE;
            thread_d = '0;
          end
        end
      end
      rrwl_pkg::OP_WRITE_REL: begin
        if (wd_q == '0) begin
          status = rrwl_pkg::ST_UNDERFLOW;
        end else begin
          wd_d = wd_q - 1'b1;
          if (wd_d == '0 && rc_q == '0) begin
            kind_d   = rrwl_pkg::KIND_NONE;
            thread_d = '0;
          end
        end
      end
      default: begin
        status = rrwl_pkg::ST_OK;
      end
    endcase
  end

  // counts are zero-extended or truncated to the 8-bit result fields
  assign rc_ext = {{rrwl_pkg::COUNT_OUT_W{1'b0}}, rc_d};
  assign wd_ext = {{rrwl_pkg::COUNT_OUT_W{1'b0}}, wd_d};

  always_comb begin
    rsp_o.status          = status;
    rsp_o.owner_kind      = kind_d;
    rsp_o.readers_held    = rc_ext[rrwl_pkg::COUNT_OUT_W-1:0];
    rsp_o.write_depth_now = wd_ext[rrwl_pkg::COUNT_OUT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q   <= rrwl_pkg::KIND_NONE;
      thread_q <= '0;
      rc_q     <= '0;
      wd_q     <= '0;
    end else if (en_i) begin
      kind_q   <= kind_d;
      thread_q <= thread_d;
      rc_q     <= rc_d;
      wd_q     <= wd_d;
    end
  end

  `RRWL_ASSERT_RST(a_none_means_idle, clk_i, rst_ni,
    (kind_q == rrwl_pkg::KIND_NONE) |-> (rc_q == '0 && wd_q == '0))
  `RRWL_ASSERT_RST(a_writer_is_single, clk_i, rst_ni,
    (wd_q != '0) |-> (kind_q == rrwl_pkg::KIND_SINGLE))
  `RRWL_ASSERT_RST(a_state_holds_when_idle, clk_i, rst_ni,
    !en_i |=> ($stable(kind_q) && $stable(rc_q) && $stable(wd_q) && $stable(thread_q)))

endmodule

`default_nettype wire

// ----- rtl/rrwl_out_reg.sv -----
`default_nettype none

module rrwl_out_reg (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           load_i,
  input  wire rrwl_pkg::rsp_t rsp_i,
  output logic                free_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output rrwl_pkg::rsp_t      out_rsp_o
);

  logic           valid_q, valid_d;
  rrwl_pkg::rsp_t rsp_q;

  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rsp_q <= rsp_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

`default_nettype wire

// ----- bench/tb_recursive_reader_writer_lock_core.sv -----
`timescale 1ns / 100ps

module tb_recursive_reader_writer_lock_core;

  localparam int unsigned CNT_MAX = 255;
  localparam int unsigned IDLE_LIMIT = 5000;
  localparam int unsigned RANDOM_ITEMS = 50;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  rrwl_pkg::req_t in_req_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  rrwl_pkg::rsp_t out_rsp_o;

  // lock state as the bench sees it
  rrwl_pkg::kind_e lock_kind = rrwl_pkg::KIND_NONE;
  logic [7:0] lock_thread = '0;
  logic [7:0] reads_held = '0;
  logic [7:0] write_levels = '0;

  rrwl_pkg::rsp_t expected_rsp_q[$];
  int unsigned err_count = 0;
  int unsigned stuck_cycles = 0;
  int unsigned src_idle_pct = 0;
  int unsigned rx_idle_pct = 0;

  recursive_reader_writer_lock_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic rrwl_pkg::rsp_t predict_lock(rrwl_pkg::req_t req);
    rrwl_pkg::rsp_t rsp;
    rrwl_pkg::status_e st;
    logic owns;
    rrwl_pkg::op_e op;
    op = rrwl_pkg::op_e'(req.operation);
    owns = (lock_kind == rrwl_pkg::KIND_SINGLE) && (lock_thread == req.thread_id);
    st = rrwl_pkg::ST_OK;
    case (op)
      rrwl_pkg::OP_READ_ACQ: begin
        if (!owns && write_levels != 0) begin
          st = rrwl_pkg::ST_WRITER;
        end else if (reads_held == CNT_MAX) begin
          st = rrwl_pkg::ST_OVERFLOW;
        end else begin
          if (!owns) begin
            if (reads_held != 0) begin
              lock_kind = rrwl_pkg::KIND_MANY;
              lock_thread = '0;
            end else begin
              lock_kind = rrwl_pkg::KIND_SINGLE;
              lock_thread = req.thread_id;
            end
          end
          reads_held = reads_held + 8'd1;
        end
      end
      rrwl_pkg::OP_WRITE_ACQ: begin
        if (owns) begin
          if (write_levels == CNT_MAX) st = rrwl_pkg::ST_OVERFLOW;
          else write_levels = write_levels + 8'd1;
        end else if (reads_held != 0) begin
          st = rrwl_pkg::ST_READER;
        end else if (write_levels != 0) begin
          st = rrwl_pkg::ST_WRITER;
        end else begin
          lock_kind = rrwl_pkg::KIND_SINGLE;
          lock_thread = req.thread_id;
          write_levels = 8'd1;
        end
      end
      rrwl_pkg::OP_READ_REL: begin
        if (reads_held == 0) st = rrwl_pkg::ST_UNDERFLOW;
        else reads_held = reads_held - 8'd1;
      end
      default: begin
        if (write_levels == 0) st = rrwl_pkg::ST_UNDERFLOW;
        else write_levels = write_levels - 8'd1;
      end
    endcase
    // a successful release that empties both counts frees the lock
    if (st == rrwl_pkg::ST_OK &&
        (op == rrwl_pkg::OP_READ_REL || op == rrwl_pkg::OP_WRITE_REL) &&
        reads_held == 0 && write_levels == 0) begin
      lock_kind = rrwl_pkg::KIND_NONE;
      lock_thread = '0;
    end
    rsp.status = st;
    rsp.owner_kind = lock_kind;
    rsp.readers_held = reads_held;
    rsp.write_depth_now = write_levels;
    return rsp;
  endfunction

  // called at a falling edge, returns at a falling edge with valid still high
  task automatic send_req(input rrwl_pkg::op_e op, input logic [7:0] tid);
    rrwl_pkg::req_t req;
    req.operation = op;
    req.thread_id = tid;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= req;
    do @(posedge clk_i); while (in_stall_o);
    expected_rsp_q.push_back(predict_lock(req));
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic compare_field(input string name, input logic [7:0] exp_val,
                               input logic [7:0] act_val);
    if (act_val !== exp_val) begin
      err_count++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d",
               $time, name, exp_val, act_val);
    end
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < rx_idle_pct);
  end

  always @(posedge clk_i) begin
    rrwl_pkg::rsp_t exp_rsp;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_rsp_q.size() == 0) begin
        err_count++;
        $display("%0t ns: response with none pending, expected nothing, actual %p",
                 $time, out_rsp_o);
      end else begin
        exp_rsp = expected_rsp_q.pop_front();
        compare_field("status", 8'(exp_rsp.status), 8'(out_rsp_o.status));
        compare_field("owner_kind", 8'(exp_rsp.owner_kind), 8'(out_rsp_o.owner_kind));
        compare_field("readers_held", exp_rsp.readers_held, out_rsp_o.readers_held);
        compare_field("write_depth_now", exp_rsp.write_depth_now,
                      out_rsp_o.write_depth_now);
      end
    end
  end

  // no progress on either channel for too long means a hang
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic test_directed();
    send_req(rrwl_pkg::OP_READ_REL, 8'h00);   // release with nothing held
    send_req(rrwl_pkg::OP_WRITE_REL, 8'h00);
    send_req(rrwl_pkg::OP_READ_ACQ, 8'h00);
    send_req(rrwl_pkg::OP_READ_ACQ, 8'h00);   // re-entry
    send_req(rrwl_pkg::OP_WRITE_ACQ, 8'h00);  // upgrade of sole reader
    send_req(rrwl_pkg::OP_READ_ACQ, 8'hFF);   // writer contending
    send_req(rrwl_pkg::OP_WRITE_ACQ, 8'hFF);  // reader contending
    send_req(rrwl_pkg::OP_WRITE_ACQ, 8'h00);  // nested write
    send_req(rrwl_pkg::OP_WRITE_REL, 8'hFF);  // any thread may release
    send_req(rrwl_pkg::OP_WRITE_REL, 8'h00);
    send_req(rrwl_pkg::OP_READ_REL, 8'h00);
    send_req(rrwl_pkg::OP_READ_REL, 8'h00);
    send_req(rrwl_pkg::OP_WRITE_ACQ, 8'hFF);
    send_req(rrwl_pkg::OP_READ_ACQ, 8'h55);
    send_req(rrwl_pkg::OP_WRITE_ACQ, 8'h55);
    send_req(rrwl_pkg::OP_READ_ACQ, 8'hFF);   // writer takes a read hold
    send_req(rrwl_pkg::OP_WRITE_REL, 8'hFF);  // owner kept, reads remain
    send_req(rrwl_pkg::OP_READ_REL, 8'hFF);
    send_req(rrwl_pkg::OP_READ_ACQ, 8'h55);
    send_req(rrwl_pkg::OP_READ_ACQ, 8'hAA);   // many readers
    send_req(rrwl_pkg::OP_WRITE_ACQ, 8'h55);
    send_req(rrwl_pkg::OP_READ_REL, 8'hAA);
    send_req(rrwl_pkg::OP_WRITE_ACQ, 8'h55);  // last reader of many cannot upgrade
    send_req(rrwl_pkg::OP_READ_REL, 8'h55);
    send_req(rrwl_pkg::OP_READ_REL, 8'h55);
  endtask

  task automatic test_count_overflow();
    repeat (CNT_MAX) send_req(rrwl_pkg::OP_READ_ACQ, 8'h3C);
    send_req(rrwl_pkg::OP_READ_ACQ, 8'h3C);
    send_req(rrwl_pkg::OP_READ_ACQ, 8'hC3);
    send_req(rrwl_pkg::OP_WRITE_ACQ, 8'h3C);  // upgrade at a full read count
    send_req(rrwl_pkg::OP_WRITE_REL, 8'($urandom));
    repeat (CNT_MAX) send_req(rrwl_pkg::OP_READ_REL, 8'($urandom));
    repeat (CNT_MAX) send_req(rrwl_pkg::OP_WRITE_ACQ, 8'h96);
    send_req(rrwl_pkg::OP_WRITE_ACQ, 8'h96);
    send_req(rrwl_pkg::OP_READ_ACQ, 8'h96);
    send_req(rrwl_pkg::OP_READ_REL, 8'($urandom));
    repeat (CNT_MAX) send_req(rrwl_pkg::OP_WRITE_REL, 8'($urandom));
    send_req(rrwl_pkg::OP_WRITE_REL, 8'($urandom));
  endtask

  // a few threads share the lock so re-entry, upgrade and contention are common
  task automatic test_random_traffic(input int unsigned n_items);
    logic [7:0] tid_pool [4];
    logic [7:0] tid;
    foreach (tid_pool[i]) tid_pool[i] = 8'($urandom);
    repeat (n_items) begin
      if ($urandom_range(9) == 0) tid = 8'($urandom);
      else tid = tid_pool[$urandom_range(3)];
      send_req(rrwl_pkg::op_e'($urandom_range(3)), tid);
      if ($urandom_range(63) == 0) wait_drained();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    src_idle_pct = 29;
    rx_idle_pct = 50;
    test_directed();
    test_count_overflow();
    test_random_traffic(RANDOM_ITEMS);
    wait_drained();

    src_idle_pct = 50;
    rx_idle_pct = 29;
    test_random_traffic(RANDOM_ITEMS);
    wait_drained();

    src_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_traffic(RANDOM_ITEMS);
    wait_drained();

    repeat (10) @(posedge clk_i);
    if (err_count == 0 && expected_rsp_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
